// ===== hw/rtl/i2c_master_write_sequencer_defines.svh =====
// Assertion macros used by the I2C master write sequencer engine RTL.
`ifndef I2C_MASTER_WRITE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_WRITE_SEQUENCER_DEFINES_SVH

// Same-cycle property, disabled while reset is asserted.
`define I2CMW_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("i2cmw assertion failed");

// Condition in one cycle implies a consequence in the next.
`define I2CMW_ASSERT_NEXT(name, clk, rst_n, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (conseq)) \
    else $error("i2cmw assertion failed");

`endif

// ===== hw/rtl/i2cmw_pkg.sv =====
// Types and constants of the I2C master write sequencer.
`default_nettype none

package i2cmw_pkg;

  localparam int unsigned COUNT_BITS = 16;

  localparam logic [2:0] BIT_MSB = 3'd7;
  localparam logic [2:0] BIT_LSB = 3'd0;

  typedef enum logic [1:0] {
    ACT_BEGIN  = 2'd0,
    ACT_SUPPLY = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_OK   = 2'd1,
    ST_NACK = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_START = 6'b000010,
    PH_BITS  = 6'b000100,
    PH_ACK   = 6'b001000,
    PH_WAIT  = 6'b010000,
    PH_STOP  = 6'b100000
  } phase_e;

  typedef struct packed {
    action_e     action;
    logic [6:0]  target_address;
    logic [15:0] byte_count;
    logic [7:0]  data_byte;
    logic        sda_sample;
  } item_t;

  typedef struct packed {
    logic    scl_drive_low;
    logic    sda_drive_low;
    logic    busy_res;
    logic    need_byte;
    status_e status;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_master_write_sequencer.sv =====
// I2C master write sequencer: input stage, bus engine and result register.
//
// Usage: every input beat carries one action: begin a write (target_address_i,
// byte_count_i), supply the next data byte (data_byte_i), or a tick
// that advances the SCL/SDA sequence and samples sda_sample_i. Action 3 is a
// no-op that still returns the current line state.
// Every accepted input beat yields exactly one output beat with the open-drain
// drive levels, busy flag, need_byte request and the finish status.
// The input register takes the beat, and the result register loads its result
// once the result slot is free. Throughput: one beat per cycle while
// out_ready_i stays high, set by the single-step next-state logic between the two registers.
// Stall: while out_ready_i is low a finished result holds in the result
// register and one further beat can still be taken into the input register;
// in_ready_o drops only when both are full.
// Reset (rst_ni low, asynchronous): engine idles with both lines released,
// byte counter and buffer cleared, no beats in flight.
`default_nettype none

module i2c_master_write_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [6:0]  target_address_i,
  input  wire logic [15:0] byte_count_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        sda_sample_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             scl_drive_low_o,
  output logic             sda_drive_low_o,
  output logic             busy_res_o,
  output logic             need_byte_o,
  output logic [1:0]       status_o
);

  logic                 in_valid_q;
  i2cmw_pkg::item_t     in_item_q;
  logic                 out_valid_q;
  i2cmw_pkg::result_t   out_res_q;
  i2cmw_pkg::result_t   eng_res;
  logic                 advance;

  // Advance the held beat into the engine whenever the result slot is free.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Capture the input beat; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q.action         <= i2cmw_pkg::action_e'(action_i);
      in_item_q.target_address <= target_address_i;
      in_item_q.byte_count     <= byte_count_i;
      in_item_q.data_byte      <= data_byte_i;
      in_item_q.sda_sample     <= sda_sample_i;
    end
  end

  i2cmw_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (eng_res)
  );

  // Result register: load on advance, drop valid once the beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= eng_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scl_drive_low_o = out_res_q.scl_drive_low;
  assign sda_drive_low_o = out_res_q.sda_drive_low;
  assign busy_res_o      = out_res_q.busy_res;
  assign need_byte_o     = out_res_q.need_byte;
  assign status_o        = out_res_q.status;

endmodule

`default_nettype wire

// ===== hw/rtl/i2cmw_engine.sv =====
// Bus sequencing state and the single-step next-state logic.
`default_nettype none

`include "i2c_master_write_sequencer_defines.svh"

module i2cmw_engine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire i2cmw_pkg::item_t   item_i,
  output i2cmw_pkg::result_t      result_o
);

  i2cmw_pkg::phase_e                   phase_q, phase_d;
  logic [1:0]                          step_q, step_d;
  logic [2:0]                          bit_q, bit_d;
  logic [7:0]                          shift_q, shift_d;
  logic [7:0]                          pend_byte_q, pend_byte_d;
  logic                                pend_valid_q, pend_valid_d;
  logic [i2cmw_pkg::COUNT_BITS-1:0]    bytes_left_q, bytes_left_d;
  logic                                nack_q, nack_d;
  logic                                scl_low_q, scl_low_d;
  logic                                sda_low_q, sda_low_d;
  i2cmw_pkg::status_e                  status_d;
  logic                                busy_now;
  logic                                busy_nxt;

  always_comb begin
    phase_d      = phase_q;
    step_d       = step_q;
    bit_d        = bit_q;
    shift_d      = shift_q;
    pend_byte_d  = pend_byte_q;
    pend_valid_d = pend_valid_q;
    bytes_left_d = bytes_left_q;
    nack_d       = nack_q;
    scl_low_d    = scl_low_q;
    sda_low_d    = sda_low_q;
    status_d     = i2cmw_pkg::ST_NONE;
    busy_now     = (phase_q != i2cmw_pkg::PH_IDLE);

    case (item_i.action)
      i2cmw_pkg::ACT_BEGIN: begin
        if (!busy_now) begin
          shift_d      = {item_i.target_address, 1'b0};
          bytes_left_d = item_i.byte_count[i2cmw_pkg::COUNT_BITS-1:0];
          pend_valid_d = 1'b0;
          nack_d       = 1'b0;
          step_d       = 2'd0;
          bit_d        = i2cmw_pkg::BIT_MSB;
          phase_d      = i2cmw_pkg::PH_START;
        end
      end
      i2cmw_pkg::ACT_SUPPLY: begin
        if (busy_now && !pend_valid_q && (bytes_left_q != '0)) begin
          pend_byte_d  = item_i.data_byte;
          pend_valid_d = 1'b1;
        end
      end
      i2cmw_pkg::ACT_TICK: begin
        case (phase_q)
          i2cmw_pkg::PH_START: begin
            case (step_q)
              2'd0: begin sda_low_d = 1'b0; step_d = 2'd1; end
              2'd1: begin scl_low_d = 1'b0; step_d = 2'd2; end
              2'd2: begin sda_low_d = 1'b1; step_d = 2'd3; end
              default: begin
                scl_low_d = 1'b1;
                step_d    = 2'd0;
                bit_d     = i2cmw_pkg::BIT_MSB;
                phase_d   = i2cmw_pkg::PH_BITS;
              end
            endcase
          end
          i2cmw_pkg::PH_BITS: begin
            if (step_q == 2'd0) begin
              sda_low_d = ~shift_q[bit_q];
              step_d    = 2'd1;
            end else if (step_q == 2'd1) begin
              scl_low_d = 1'b0;
              step_d    = 2'd2;
            end else begin
              scl_low_d = 1'b1;
              step_d    = 2'd0;
              if (bit_q == i2cmw_pkg::BIT_LSB) begin
                phase_d = i2cmw_pkg::PH_ACK;
              end else begin
                bit_d = bit_q - 3'd1;
              end
            end
          end
          i2cmw_pkg::PH_ACK: begin
            if (step_q == 2'd0) begin
              sda_low_d = 1'b0;
              step_d    = 2'd1;
            end else if (step_q == 2'd1) begin
              scl_low_d = 1'b0;
              step_d    = 2'd2;
            end else begin
              scl_low_d = 1'b1;
              step_d    = 2'd0;
              if (item_i.sda_sample) begin
                nack_d  = 1'b1;
                phase_d = i2cmw_pkg::PH_STOP;
              end else if (bytes_left_q == '0) begin
                phase_d = i2cmw_pkg::PH_STOP;
              end else begin
                phase_d = i2cmw_pkg::PH_WAIT;
              end
            end
          end
          i2cmw_pkg::PH_WAIT: begin
            // Load the buffered byte and drive its MSB in the same step.
            if (pend_valid_q) begin
              shift_d      = pend_byte_q;
              pend_valid_d = 1'b0;
              bytes_left_d = bytes_left_q - {{(i2cmw_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
              bit_d        = i2cmw_pkg::BIT_MSB;
              phase_d      = i2cmw_pkg::PH_BITS;
              sda_low_d    = ~pend_byte_q[i2cmw_pkg::BIT_MSB];
              step_d       = 2'd1;
            end
          end
          i2cmw_pkg::PH_STOP: begin
            if (step_q == 2'd0) begin
              sda_low_d = 1'b1;
              step_d    = 2'd1;
            end else if (step_q == 2'd1) begin
              scl_low_d = 1'b0;
              step_d    = 2'd2;
            end else begin
              sda_low_d    = 1'b0;
              step_d       = 2'd0;
              status_d     = nack_q ? i2cmw_pkg::ST_NACK : i2cmw_pkg::ST_OK;
              phase_d      = i2cmw_pkg::PH_IDLE;
              bytes_left_d = '0;
              pend_valid_d = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    busy_nxt = (phase_d != i2cmw_pkg::PH_IDLE);
  end

  assign result_o.scl_drive_low = scl_low_d;
  assign result_o.sda_drive_low = sda_low_d;
  assign result_o.busy_res      = busy_nxt;
  assign result_o.need_byte     = busy_nxt && !pend_valid_d && (bytes_left_d != '0);
  assign result_o.status        = status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= i2cmw_pkg::PH_IDLE;
      step_q       <= 2'd0;
      bit_q        <= i2cmw_pkg::BIT_MSB;
      shift_q      <= '0;
      pend_valid_q <= 1'b0;
      bytes_left_q <= '0;
      nack_q       <= 1'b0;
      scl_low_q    <= 1'b0;
      sda_low_q    <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      step_q       <= step_d;
      bit_q        <= bit_d;
      shift_q      <= shift_d;
      pend_valid_q <= pend_valid_d;
      bytes_left_q <= bytes_left_d;
      nack_q       <= nack_d;
      scl_low_q    <= scl_low_d;
      sda_low_q    <= sda_low_d;
    end
  end

  // Byte buffer: only read while its valid flag is set.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      pend_byte_q <= pend_byte_d;
    end
  end

  `I2CMW_ASSERT(a_idle_buffer_empty, clk_i, rst_ni,
    (phase_q != i2cmw_pkg::PH_IDLE) || !pend_valid_q)
  `I2CMW_ASSERT(a_step_range, clk_i, rst_ni,
    (phase_q == i2cmw_pkg::PH_START) || (step_q != 2'd3))
  `I2CMW_ASSERT(a_status_only_at_end, clk_i, rst_ni,
    !step_i || (result_o.status == i2cmw_pkg::ST_NONE) || !result_o.busy_res)
  `I2CMW_ASSERT_NEXT(a_stop_to_idle, clk_i, rst_ni,
    step_i && (item_i.action == i2cmw_pkg::ACT_TICK) &&
    (phase_q == i2cmw_pkg::PH_STOP) && (step_q == 2'd2),
    phase_q == i2cmw_pkg::PH_IDLE)

endmodule

`default_nettype wire
